### src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/pss_pkg.sv
// Types, constants and helpers shared by the priority scheduler modules.
package pss_pkg;

    localparam int MAX_PROCS_DEF = 32;

    localparam int BURST_W = 16;
    localparam int TIME_W  = 16;
    localparam int PRIO_W  = 8;
    localparam int ID_W    = 6;
    localparam int WAIT_W  = 22;
    localparam int TOT_W   = 27;

    localparam logic [WAIT_W-1:0] WAIT_MAX = '1;
    localparam logic [TOT_W-1:0]  TOT_MAX  = '1;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [BURST_W-1:0] burst_time;
        logic [TIME_W-1:0]  arrival_time;
        logic [PRIO_W-1:0]  prio_level;
        logic               last;
    } item_t;

    typedef struct packed {
        logic [ID_W-1:0]   process_id;
        logic [WAIT_W-1:0] waiting_time;
        logic [WAIT_W-1:0] turnaround_time;
        logic [TOT_W-1:0]  total_wait;
        logic [TOT_W-1:0]  total_turnaround;
        logic              last_out;
    } result_t;

    // One entry of the schedule-ordered list: sort key plus what emission needs.
    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [TIME_W-1:0]  arrive;
        logic [BURST_W-1:0] burst;
        logic [ID_W-1:0]    pid;
    } ord_entry_t;

    // One scheduled record handed from front to back.
    typedef struct packed {
        logic [BURST_W-1:0] burst;
        logic [TIME_W-1:0]  arrive;
        logic [ID_W-1:0]    pid;
        logic               last;
    } task_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_LOAD,
        F_WALK,
        F_PLACE,
        F_EREAD,
        F_EPUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_WAIT,
        B_TURN,
        B_OUT
    } back_state_t;

    // True when a stored entry must be served after a new record (p, t).
    function automatic logic goes_after(ord_entry_t e, logic [PRIO_W-1:0] p,
                                        logic [TIME_W-1:0] t);
        return (e.prio > p) || ((e.prio == p) && (e.arrive > t));
    endfunction

endpackage

### src/pss_queue.sv
// Short request queue between the front and back parts of the scheduler.
module pss_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    output logic          full,
    input  pss_pkg::task_t wdata,
    input  logic          rd,
    output logic          empty,
    output pss_pkg::task_t rdata
);
    import pss_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    task_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_wr, do_rd;

    assign full  = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = slot_reg[rptr_reg];
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_wr)
        begin
            wptr_next = (wptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rptr_next = (rptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

endmodule

### src/pss_front.sv
// Front part: loads records, keeps them in schedule order, streams them out.
module pss_front #(
    parameter int MAX_PROCS = pss_pkg::MAX_PROCS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  pss_pkg::item_t item,
    output logic           q_wr,
    input  logic           q_full,
    output pss_pkg::task_t q_data
);
    import pss_pkg::*;

    localparam int ADDR_W = $clog2(MAX_PROCS);
    localparam int CNT_W  = $clog2(MAX_PROCS + 1);

    ord_entry_t          ord_mem [MAX_PROCS];
    ord_entry_t          rd_reg;

    front_state_t        state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ADDR_W-1:0]   pos_reg, pos_next;
    logic [ADDR_W-1:0]   k_reg, k_next;
    ord_entry_t          new_reg, new_next;
    logic                last_reg, last_next;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    ord_entry_t          wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;

    logic [6:0]          pid_wide;
    logic [CNT_W-1:0]    cnt_dec;
    logic                emit_last;

    assign full      = (state_reg != F_IDLE);
    assign pid_wide  = 7'(count_reg) + 7'd1;
    assign cnt_dec   = count_reg - CNT_W'(1);
    assign emit_last = ((CNT_W'(k_reg) + CNT_W'(1)) == count_reg);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        k_next     = k_reg;
        new_next   = new_reg;
        last_next  = last_reg;
        wr_en      = 1'b0;
        wr_addr    = pos_reg;
        wr_data    = new_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        q_wr       = 1'b0;
        q_data     = '0;

        case (state_reg)
            F_IDLE:
            begin
                if (push)
                begin
                    new_next.prio   = item.prio_level;
                    new_next.arrive = item.arrival_time;
                    new_next.burst  = item.burst_time;
                    new_next.pid    = pid_wide[ID_W-1:0];
                    last_next       = item.last;
                    state_next      = F_LOAD;
                end
            end
            F_LOAD:
            begin
                k_next = '0;
                if (count_reg == CNT_W'(MAX_PROCS))
                begin
                    // store full: drop the record
                    state_next = last_reg ? F_EREAD : F_IDLE;
                end
                else if (count_reg == '0)
                begin
                    pos_next   = '0;
                    state_next = F_PLACE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = cnt_dec[ADDR_W-1:0];
                    pos_next   = count_reg[ADDR_W-1:0];
                    state_next = F_WALK;
                end
            end
            F_WALK:
            begin
                wr_en   = 1'b1;
                wr_addr = pos_reg;
                if (goes_after(rd_reg, new_reg.prio, new_reg.arrive))
                begin
                    // shift the later entry up one place and look further down
                    wr_data  = rd_reg;
                    pos_next = pos_reg - ADDR_W'(1);
                    if (pos_reg == ADDR_W'(1))
                    begin
                        state_next = F_PLACE;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = pos_reg - ADDR_W'(2);
                    end
                end
                else
                begin
                    wr_data    = new_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = last_reg ? F_EREAD : F_IDLE;
                end
            end
            F_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = new_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = last_reg ? F_EREAD : F_IDLE;
            end
            F_EREAD:
            begin
                rd_en      = 1'b1;
                rd_addr    = k_reg;
                state_next = F_EPUSH;
            end
            F_EPUSH:
            begin
                if (!q_full)
                begin
                    q_wr          = 1'b1;
                    q_data.burst  = rd_reg.burst;
                    q_data.arrive = rd_reg.arrive;
                    q_data.pid    = rd_reg.pid;
                    q_data.last   = emit_last;
                    if (emit_last)
                    begin
                        count_next = '0;
                        state_next = F_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + ADDR_W'(1);
                        state_next = F_EREAD;
                    end
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        k_reg    <= k_next;
        new_reg  <= new_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ord_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= ord_mem[rd_addr];
        end
    end

endmodule

### src/pss_back.sv
// Back part: works out start, wait, turnaround and running totals per record.
module pss_back #(
    parameter int MAX_PROCS = pss_pkg::MAX_PROCS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    output logic             q_rd,
    input  pss_pkg::task_t   q_data,
    output logic             empty,
    input  logic             pop,
    output pss_pkg::result_t result
);
    import pss_pkg::*;

    localparam int START_W = BURST_W + $clog2(MAX_PROCS) + 1;
    localparam int CALC_W  = (START_W > WAIT_W) ? START_W : WAIT_W + 1;
    localparam int TA_W    = WAIT_W + 1;
    localparam int TS_W    = TOT_W + 1;

    back_state_t         state_reg, state_next;
    logic                first_reg, first_next;
    logic [START_W-1:0]  start_reg, start_next;
    logic [BURST_W-1:0]  pburst_reg, pburst_next;
    task_t               cur_reg, cur_next;
    logic [WAIT_W-1:0]   w_reg, w_next;
    logic [WAIT_W-1:0]   ta_reg, ta_next;
    logic [TOT_W-1:0]    tw_reg, tw_next;
    logic [TOT_W-1:0]    tt_reg, tt_next;
    result_t             out_reg, out_next;
    logic                ovld_reg, ovld_next;

    logic [CALC_W-1:0]   diff;
    logic [TA_W-1:0]     ta_sum;
    logic [TS_W-1:0]     tw_sum;
    logic [TS_W-1:0]     tt_sum;
    logic [TOT_W-1:0]    tt_sat;

    assign empty  = !ovld_reg;
    assign result = out_reg;

    assign diff   = (start_reg > START_W'(cur_reg.arrive))
                  ? CALC_W'(start_reg) - CALC_W'(cur_reg.arrive) : '0;
    assign ta_sum = TA_W'(w_reg) + TA_W'(cur_reg.burst);
    assign tw_sum = TS_W'(tw_reg) + TS_W'(w_reg);
    assign tt_sum = TS_W'(tt_reg) + TS_W'(ta_reg);
    assign tt_sat = tt_sum[TOT_W] ? TOT_MAX : tt_sum[TOT_W-1:0];

    always_comb
    begin
        state_next  = state_reg;
        first_next  = first_reg;
        start_next  = start_reg;
        pburst_next = pburst_reg;
        cur_next    = cur_reg;
        w_next      = w_reg;
        ta_next     = ta_reg;
        tw_next     = tw_reg;
        tt_next     = tt_reg;
        out_next    = out_reg;
        ovld_next   = ovld_reg;
        q_rd        = 1'b0;

        if (pop && ovld_reg)
        begin
            ovld_next = 1'b0;
        end

        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_rd        = 1'b1;
                    cur_next    = q_data;
                    start_next  = first_reg ? START_W'(q_data.arrive)
                                            : start_reg + START_W'(pburst_reg);
                    pburst_next = q_data.burst;
                    first_next  = 1'b0;
                    state_next  = B_WAIT;
                end
            end
            B_WAIT:
            begin
                w_next     = (diff > CALC_W'(WAIT_MAX)) ? WAIT_MAX : diff[WAIT_W-1:0];
                state_next = B_TURN;
            end
            B_TURN:
            begin
                ta_next    = ta_sum[WAIT_W] ? WAIT_MAX : ta_sum[WAIT_W-1:0];
                tw_next    = tw_sum[TOT_W] ? TOT_MAX : tw_sum[TOT_W-1:0];
                state_next = B_OUT;
            end
            B_OUT:
            begin
                if (!ovld_reg || pop)
                begin
                    out_next.process_id       = cur_reg.pid;
                    out_next.waiting_time     = w_reg;
                    out_next.turnaround_time  = ta_reg;
                    out_next.total_wait       = tw_reg;
                    out_next.total_turnaround = tt_sat;
                    out_next.last_out         = cur_reg.last;
                    ovld_next                 = 1'b1;
                    tt_next                   = tt_sat;
                    if (cur_reg.last)
                    begin
                        // schedule done: rewind for the next set
                        first_next = 1'b1;
                        tw_next    = '0;
                        tt_next    = '0;
                    end
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            first_reg <= 1'b1;
            tw_reg    <= '0;
            tt_reg    <= '0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
            tw_reg    <= tw_next;
            tt_reg    <= tt_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg  <= start_next;
        pburst_reg <= pburst_next;
        cur_reg    <= cur_next;
        w_reg      <= w_next;
        ta_reg     <= ta_next;
        out_reg    <= out_next;
    end

endmodule

### src/priority_schedule_with_arrival.sv
// Top level of the non-preemptive priority scheduler with arrival times.
//
//   Channel  | Handshake          | Payload           | Moves
//   ---------+--------------------+-------------------+------------------------------
//   input    | push / full        | item   (item_t)   | one process record a request
//   result   | pop / empty        | result (result_t) | one scheduled record a request
//
// Loading a record walks down the order memory, moving each stored entry that must
// be served after it up one place to make room, then writes the record in. The
// record marked last starts emission: the front reads each ordered entry and pushes
// it into the queue; the back part takes each result through its wait, turnaround
// and output states, which sets the emission rate. The input stays full from
// acceptance until the record is stored, or after the last until all are queued.
// Reset is asynchronous and active low; the order memory needs no clearing.
// A stalled result holds on the result port and backs up through the queue.
module priority_schedule_with_arrival #(
    parameter int MAX_PROCS = pss_pkg::MAX_PROCS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  pss_pkg::item_t   item,
    output logic             empty,
    input  logic             pop,
    output pss_pkg::result_t result
);
    import pss_pkg::*;

    // Internal request queue between the two halves.
    logic  q_wr;
    logic  q_full;
    logic  q_rd;
    logic  q_empty;
    task_t q_wdata;
    task_t q_rdata;

    // Front: accept records and hold them in schedule order.
    pss_front #(
        .MAX_PROCS (MAX_PROCS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .q_wr   (q_wr),
        .q_full (q_full),
        .q_data (q_wdata)
    );

    // Queue: decouple the front from stalls on the result side.
    pss_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .full  (q_full),
        .wdata (q_wdata),
        .rd    (q_rd),
        .empty (q_empty),
        .rdata (q_rdata)
    );

    // Back: advance the service clock and produce one result per record.
    pss_back #(
        .MAX_PROCS (MAX_PROCS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_rd    (q_rd),
        .q_data  (q_rdata),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

### src/pss_checker.sv
// Port-level checker for the priority scheduler, bound to the top level.
`include "assert_macros.svh"

module pss_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             push,
    input logic             full,
    input logic             empty,
    input logic             pop,
    input pss_pkg::result_t result
);

    `ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(result), "stalled result changed")
    `ASSERT_NEXT(a_busy_after_accept, push && !full, full, "input not held off after a request")
    `ASSERT_IMPLIES(a_turn_ge_wait, !empty, result.turnaround_time >= result.waiting_time, "turnaround below wait")
    `ASSERT_IMPLIES(a_totals_ge_item, !empty, (result.total_wait >= result.waiting_time) && (result.total_turnaround >= result.turnaround_time), "running total below item")

endmodule

bind priority_schedule_with_arrival pss_checker u_pss_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
